// ===== hdl/hlpc_pkg.sv =====
// Package for the heading lock controller: types, register indexes, status codes.
package hlpc_pkg;

    // Angle width is fixed by the heading fields (one turn = 2^ANGLE_BITS)
    localparam int ANGLE_BITS        = 16;
    localparam int LOCK_RUN_DEF      = 2;
    localparam int CFG_IDX_BITS      = 3;
    localparam int CFG_DATA_BITS     = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_BITS-1:0] REG_TARGET    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TOLERANCE = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_KP_GAIN   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_CAP       = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_FLOOR     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_TICKS = 3'd5;

    // Lock status codes
    localparam logic [1:0] STAT_DRIVE   = 2'd0;
    localparam logic [1:0] STAT_LOCKED  = 2'd1;
    localparam logic [1:0] STAT_TIMEOUT = 2'd2;
    localparam logic [1:0] STAT_IDLE    = 2'd3;

    // Register reset values
    localparam logic [15:0] TARGET_RST    = 16'd0;
    localparam logic [8:0]  TOLERANCE_RST = 9'd455;
    localparam logic [15:0] KP_GAIN_RST   = 16'd1608;
    localparam logic [14:0] CAP_RST       = 15'd3277;
    localparam logic [14:0] FLOOR_RST     = 15'd901;
    localparam logic [11:0] MAX_TICKS_RST = 12'd125;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] target_heading;
        logic [8:0]            heading_tolerance;
        logic [15:0]           kp_gain;
        logic [14:0]           rate_cap;
        logic [14:0]           omega_floor;
        logic [11:0]           max_lock_ticks;
    } t_cfg;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] measured_heading;
        logic                  restart;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] omega_cmd;
        logic [1:0]         lock_status;
    } t_out_beat;

endpackage

// ===== hdl/hlpc_cfg_regs.sv =====
// Configuration register file of the heading lock controller.
module hlpc_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [hlpc_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [hlpc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output hlpc_pkg::t_cfg                      o_cfg
);

    hlpc_pkg::t_cfg r_cfg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_heading    <= hlpc_pkg::TARGET_RST;
            r_cfg.heading_tolerance <= hlpc_pkg::TOLERANCE_RST;
            r_cfg.kp_gain           <= hlpc_pkg::KP_GAIN_RST;
            r_cfg.rate_cap          <= hlpc_pkg::CAP_RST;
            r_cfg.omega_floor       <= hlpc_pkg::FLOOR_RST;
            r_cfg.max_lock_ticks    <= hlpc_pkg::MAX_TICKS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                hlpc_pkg::REG_TARGET:    r_cfg.target_heading    <= i_cfg_data[15:0];
                hlpc_pkg::REG_TOLERANCE: r_cfg.heading_tolerance <= i_cfg_data[8:0];
                hlpc_pkg::REG_KP_GAIN:   r_cfg.kp_gain           <= i_cfg_data[15:0];
                hlpc_pkg::REG_CAP:       r_cfg.rate_cap          <= i_cfg_data[14:0];
                hlpc_pkg::REG_FLOOR:     r_cfg.omega_floor       <= i_cfg_data[14:0];
                hlpc_pkg::REG_MAX_TICKS: r_cfg.max_lock_ticks    <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/hlpc_law.sv =====
// Proportional law: wrapped heading error, tolerance check, scaled and limited rate.
module hlpc_law (
    input  hlpc_pkg::t_cfg                        i_cfg,
    input  logic [hlpc_pkg::ANGLE_BITS-1:0]       i_heading,
    output logic                                  o_in_tol,
    output logic signed [15:0]                    o_omega
);

    localparam int AB = hlpc_pkg::ANGLE_BITS;
    localparam int PW = AB + 18;     // product width: error (AB+1) times gain (17)
    localparam int SW = PW - 12;     // width after the Q12 shift

    logic [AB-1:0]        diff;
    logic signed [AB:0]   err;
    logic [AB:0]          abs_err;
    logic signed [PW-1:0] prod;
    logic signed [SW-1:0] raw;
    logic signed [SW-1:0] cap_pos;
    logic signed [SW-1:0] cap_neg;
    logic signed [SW-1:0] flr_pos;
    logic signed [SW-1:0] clamped;
    logic signed [SW-1:0] mag;
    logic signed [SW-1:0] final_w;

    // Modular difference, mapped into (-half turn, +half turn]
    always_comb begin
        diff = i_heading;
        diff = i_cfg.target_heading - i_heading;
        if (diff > {1'b1, {(AB-1){1'b0}}}) begin
            err = $signed({1'b1, diff});
        end else begin
            err = $signed({1'b0, diff});
        end
        abs_err = err[AB] ? (AB+1)'(-err) : err;
    end

    assign o_in_tol = abs_err <= (AB+1)'(i_cfg.heading_tolerance);

    // Rate: (err * gain) >>> 12, then clamp to cap, then raise to floor
    always_comb begin
        prod    = PW'(err) * $signed({{(PW-17){1'b0}}, 1'b0, i_cfg.kp_gain});
        raw     = prod[PW-1:12];
        cap_pos = $signed(SW'(i_cfg.rate_cap));
        cap_neg = -cap_pos;
        flr_pos = $signed(SW'(i_cfg.omega_floor));
        if (raw > cap_pos) begin
            clamped = cap_pos;
        end else if (raw < cap_neg) begin
            clamped = cap_neg;
        end else begin
            clamped = raw;
        end
        mag = clamped[SW-1] ? -clamped : clamped;
        if (mag < flr_pos) begin
            final_w = clamped[SW-1] ? -flr_pos : flr_pos;
        end else begin
            final_w = clamped;
        end
    end

    assign o_omega = final_w[15:0];

endmodule

// ===== hdl/heading_lock_p_controller.sv =====
// Heading lock controller top: input register, session state, result register.
// A beat accepted into the input register moves on into the result register, with
// o_out_valid high, once the result register is free or being taken; a single
// multiply-and-clamp path sits between the two. Throughput: one beat per cycle while
// the output is not stalled; the session counters update per beat.
// Reset (i_rst_n low, synchronous): registers return to defaults, counters clear, idle.
module heading_lock_p_controller #(
    parameter int LOCK_RUN_LEN = hlpc_pkg::LOCK_RUN_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  hlpc_pkg::t_in_beat                  i_in_beat,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output hlpc_pkg::t_out_beat                 o_out_beat,
    input  logic                                i_out_stall,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [hlpc_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [hlpc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam logic [1:0] GOOD_NEED = 2'(LOCK_RUN_LEN);

    hlpc_pkg::t_cfg      cfg;
    hlpc_pkg::t_in_beat  r_in;
    logic                r_in_valid;
    hlpc_pkg::t_out_beat r_out;
    hlpc_pkg::t_out_beat n_out;
    logic                r_out_valid;
    logic [1:0]          r_good;
    logic [1:0]          n_good;
    logic [11:0]         r_elapsed;
    logic [11:0]         n_elapsed;
    logic                r_active;
    logic                n_active;
    logic                advance;
    logic                in_tol;
    logic signed [15:0]  omega;
    logic [1:0]          good_inc;

    hlpc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    hlpc_law u_law (
        .i_cfg     (cfg),
        .i_heading (r_in.measured_heading),
        .o_in_tol  (in_tol),
        .o_omega   (omega)
    );

    assign o_cfg_ready = 1'b1;

    // Pipeline moves when the result register is free or being taken
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_beat;
        end
    end

    // Session logic for the beat in the input register
    always_comb begin
        n_good    = r_good;
        n_elapsed = r_elapsed;
        n_active  = r_active;
        n_out.omega_cmd   = '0;
        n_out.lock_status = hlpc_pkg::STAT_IDLE;
        good_inc  = (r_good == 2'd3) ? r_good : r_good + 2'd1;
        if (r_in.restart) begin
            n_good    = '0;
            n_elapsed = '0;
            n_active  = 1'b1;
            good_inc  = 2'd1;
        end
        if (n_active) begin
            if (n_elapsed >= cfg.max_lock_ticks) begin
                n_active          = 1'b0;
                n_out.lock_status = hlpc_pkg::STAT_TIMEOUT;
            end else begin
                n_elapsed = n_elapsed + 12'd1;
                if (in_tol) begin
                    n_good = good_inc;
                end else begin
                    n_good = '0;
                end
                if (in_tol && good_inc >= GOOD_NEED) begin
                    n_active          = 1'b0;
                    n_out.lock_status = hlpc_pkg::STAT_LOCKED;
                end else begin
                    n_out.omega_cmd   = omega;
                    n_out.lock_status = hlpc_pkg::STAT_DRIVE;
                end
            end
        end
    end

    // Session state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_good      <= '0;
            r_elapsed   <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_good    <= n_good;
                r_elapsed <= n_elapsed;
                r_active  <= n_active;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the heading lock controller: directed and random sessions.
module tb_top;

    localparam int LOCK_RUN    = hlpc_pkg::LOCK_RUN_DEF;
    localparam int QUIET_LIMIT = 1000;   // cycles with no beat on any channel
    localparam int MAX_REPORTS = 10;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_in_valid = 1'b0;
    hlpc_pkg::t_in_beat                  i_in_beat = '0;
    logic                                o_in_stall;
    logic                                o_out_valid;
    hlpc_pkg::t_out_beat                 o_out_beat;
    logic                                i_out_stall = 1'b0;
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [hlpc_pkg::CFG_IDX_BITS-1:0]   i_cfg_index = hlpc_pkg::REG_TARGET;
    logic [hlpc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data = '0;

    // Shadow of the controller: registers and session state
    hlpc_pkg::t_cfg ctrl_cfg;
    logic [1:0]     good_run;
    logic [11:0]    ticks_used;
    logic           session_on;

    hlpc_pkg::t_out_beat pending_cmds[$];
    int unsigned ticks_sent = 0;
    int unsigned cmds_checked = 0;
    int unsigned bad_count = 0;
    int unsigned quiet_cycles = 0;
    bit          idling_on = 1'b0;

    heading_lock_p_controller DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_beat   (i_in_beat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 0;
    end

    // Expected command for one tick; advances the shadow session state
    function automatic hlpc_pkg::t_out_beat predict_heading_cmd(
            input hlpc_pkg::t_in_beat tick);
        hlpc_pkg::t_out_beat cmd;
        logic [15:0]         diff;
        longint              herr, mag, rate, cap, flr;
        cmd.omega_cmd   = '0;
        cmd.lock_status = hlpc_pkg::STAT_IDLE;
        if (tick.restart) begin
            good_run   = '0;
            ticks_used = '0;
            session_on = 1'b1;
        end
        if (!session_on)
            return cmd;
        if (ticks_used >= ctrl_cfg.max_lock_ticks) begin
            session_on      = 1'b0;
            cmd.lock_status = hlpc_pkg::STAT_TIMEOUT;
            return cmd;
        end
        ticks_used = ticks_used + 12'd1;

        // Error wrapped to one turn; exactly half a turn stays positive
        diff = ctrl_cfg.target_heading - tick.measured_heading;
        herr = (diff > 16'h8000) ? longint'(diff) - 65536 : longint'(diff);
        mag  = (herr < 0) ? -herr : herr;
        if (mag <= longint'(ctrl_cfg.heading_tolerance)) begin
            if (good_run != 2'd3)
                good_run = good_run + 2'd1;
            if (good_run >= LOCK_RUN) begin
                session_on      = 1'b0;
                cmd.lock_status = hlpc_pkg::STAT_LOCKED;
                return cmd;
            end
        end else begin
            good_run = '0;
        end

        // P law, floor shift, clamp, then minimum magnitude (zero counts as positive)
        cap  = ctrl_cfg.rate_cap;
        flr  = ctrl_cfg.omega_floor;
        rate = (herr * longint'(ctrl_cfg.kp_gain)) >>> 12;
        if (rate > cap)
            rate = cap;
        if (rate < -cap)
            rate = -cap;
        if (((rate < 0) ? -rate : rate) < flr)
            rate = (rate >= 0) ? flr : -flr;
        cmd.omega_cmd   = rate[15:0];
        cmd.lock_status = hlpc_pkg::STAT_DRIVE;
        return cmd;
    endfunction

    // Send one tick beat, with an optional idle burst ahead of it
    task automatic send_tick(input logic [15:0] heading, input logic restart);
        hlpc_pkg::t_in_beat beat;
        beat.measured_heading = heading;
        beat.restart          = restart;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= beat;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_cmds.push_back(predict_heading_cmd(beat));
        ticks_sent++;
    endtask

    // Stop sending and wait for every outstanding command
    task automatic drain();
        i_in_valid <= 1'b0;
        while (cmds_checked != ticks_sent) @(posedge i_clk);
    endtask

    // Write all six registers back to back; block is idle here
    task automatic load_config(input hlpc_pkg::t_cfg c);
        logic [hlpc_pkg::CFG_IDX_BITS-1:0]  regs[6];
        logic [hlpc_pkg::CFG_DATA_BITS-1:0] vals[6];
        regs = '{hlpc_pkg::REG_TARGET, hlpc_pkg::REG_TOLERANCE, hlpc_pkg::REG_KP_GAIN,
                 hlpc_pkg::REG_CAP, hlpc_pkg::REG_FLOOR, hlpc_pkg::REG_MAX_TICKS};
        vals = '{c.target_heading, 16'(c.heading_tolerance), c.kp_gain,
                 16'(c.rate_cap), 16'(c.omega_floor), 16'(c.max_lock_ticks)};
        for (int k = 0; k < 6; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[k];
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        ctrl_cfg = c;
    endtask

    function automatic hlpc_pkg::t_cfg make_cfg(input int unsigned tgt, input int unsigned tol,
                                      input int unsigned gain, input int unsigned cap,
                                      input int unsigned flr, input int unsigned budget);
        hlpc_pkg::t_cfg c;
        c.target_heading    = tgt[15:0];
        c.heading_tolerance = tol[8:0];
        c.kp_gain           = gain[15:0];
        c.rate_cap          = cap[14:0];
        c.omega_floor       = flr[14:0];
        c.max_lock_ticks    = budget[11:0];
        return c;
    endfunction

    // Field extreme now and then, otherwise a typical value
    function automatic int unsigned pick(input int unsigned lo, input int unsigned hi,
                                         input int unsigned typ_lo, input int unsigned typ_hi);
        case ($urandom_range(0, 7))
            0: return lo;
            1: return hi;
            default: return $urandom_range(typ_lo, typ_hi);
        endcase
    endfunction

    // Defaults after reset: idle, floor on both signs, lock, idle after lock
    task automatic test_reset_defaults();
        send_tick(16'h1234, 1'b0);
        send_tick(16'd1000, 1'b1);
        send_tick(16'd0, 1'b0);
        send_tick(16'd100, 1'b0);
        send_tick(16'd0, 1'b0);
    endtask

    // Wrap edges with full gain and zero tolerance, then with the widest tolerance
    task automatic test_wrap_extremes();
        drain();
        load_config(make_cfg(0, 0, 65535, 32767, 0, 4095));
        idling_on = 1'b1;
        send_tick(16'h8000, 1'b1);
        send_tick(16'h8001, 1'b0);
        send_tick(16'h7FFF, 1'b0);
        send_tick(16'hFFFF, 1'b0);
        send_tick(16'h0001, 1'b0);
        send_tick(16'h0000, 1'b0);
        send_tick(16'h0000, 1'b0);
        drain();
        load_config(make_cfg(65535, 511, 65535, 32767, 0, 4095));
        send_tick(16'h0000, 1'b1);
        send_tick(16'hFDFF, 1'b0);
        send_tick(16'h0000, 1'b0);
    endtask

    // Zero gain, zero cap, floor above cap, then budget running out
    task automatic test_floor_and_timeout();
        drain();
        load_config(make_cfg(65535, 511, 0, 0, 32767, 3));
        send_tick(16'h8000, 1'b1);
        send_tick(16'h7FFF, 1'b0);
        send_tick(16'hFDA7, 1'b0);
        send_tick(16'h1111, 1'b0);
        send_tick(16'h2222, 1'b0);
        idling_on = 1'b0;
    endtask

    // A zero budget times out on the restart tick itself
    task automatic test_zero_budget();
        drain();
        load_config(make_cfg(4660, 146, 1608, 3277, 901, 0));
        send_tick(16'd4660, 1'b1);
        send_tick(16'hFFFF, 1'b1);
        send_tick(16'd4660, 1'b0);
    endtask

    // One lock session: restart, then errors mostly near tolerance
    task automatic run_session();
        int unsigned len;
        int          err;
        int          tol;
        len = $urandom_range(1, 40);
        tol = ctrl_cfg.heading_tolerance;
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 7))
                0: err = $urandom_range(0, 65535);
                1: err = $urandom_range(0, 1) ? tol : -tol;
                2: err = $urandom_range(0, 1) ? tol + 1 : -(tol + 1);
                3, 4, 5: err = int'($urandom_range(0, 2 * tol)) - tol;
                6: err = int'($urandom_range(0, 8191)) - 4096;
                default: err = $urandom_range(0, 1) ? 32768 : -32767;
            endcase
            send_tick(ctrl_cfg.target_heading - 16'(err), k == 0 || $urandom_range(0, 19) == 0);
        end
    endtask

    // Random settings per phase; the last phase runs without idling
    task automatic test_random_sessions();
        int unsigned start;
        for (int p = 0; p < 8; p++) begin
            drain();
            load_config(make_cfg(pick(0, 65535, 0, 65535), pick(0, 511, 146, 455),
                                 pick(0, 65535, 1608, 65535), pick(0, 32767, 3277, 32767),
                                 pick(0, 32767, 0, 2000), pick(0, 4095, 1, 40)));
            idling_on = (p != 7) && ($urandom_range(0, 2) != 0);
            start = ticks_sent;
            while (ticks_sent - start < 100) begin
                if ($urandom_range(0, 9) == 0)
                    send_tick(16'($urandom_range(0, 65535)), 1'b0);
                else
                    run_session();
            end
        end
    endtask

    // Receiver stall bursts
    initial begin
        forever begin
            @(posedge i_clk);
            if (idling_on && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
        end
    end

    // Compare each command beat with the oldest expectation
    always @(posedge i_clk) begin
        hlpc_pkg::t_out_beat want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (pending_cmds.size() == 0) begin
                bad_count++;
                if (bad_count <= MAX_REPORTS)
                    $display("unexpected command beat: omega %0d status %0d",
                             o_out_beat.omega_cmd, o_out_beat.lock_status);
            end else begin
                want = pending_cmds.pop_front();
                cmds_checked++;
                if (o_out_beat.omega_cmd !== want.omega_cmd
                        || o_out_beat.lock_status !== want.lock_status) begin
                    bad_count++;
                    if (bad_count <= MAX_REPORTS)
                        $display({"command %0d: expected omega %0d status %0d, ",
                                  "got omega %0d status %0d"},
                                 cmds_checked, want.omega_cmd, want.lock_status,
                                 o_out_beat.omega_cmd, o_out_beat.lock_status);
                end
            end
        end
    end

    // Watchdog on cycles with no beat anywhere
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("heading_lock_p_controller: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        ctrl_cfg   = make_cfg(hlpc_pkg::TARGET_RST, hlpc_pkg::TOLERANCE_RST,
                              hlpc_pkg::KP_GAIN_RST, hlpc_pkg::CAP_RST,
                              hlpc_pkg::FLOOR_RST, hlpc_pkg::MAX_TICKS_RST);
        good_run   = '0;
        ticks_used = '0;
        session_on = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_wrap_extremes();
        test_floor_and_timeout();
        test_zero_budget();
        test_random_sessions();

        drain();
        repeat (8) @(posedge i_clk);
        if (bad_count == 0 && pending_cmds.size() == 0)
            $display("heading_lock_p_controller: match");
        else
            $display("heading_lock_p_controller: mismatch");
        $finish;
    end

endmodule
